/* hdl/hrb_pkg.sv */
// Shared types and constants for the history ring buffer.
// No dependencies; imported by hrb_cell and history_ring_buffer_core.
`default_nettype none

package hrb_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int COUNT_W      = 8;
    localparam int SEQ_W        = 32;
    localparam int FIELD_W      = 16;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_READ   = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_SEQ    = 2'd3
    } req_t;

    typedef struct packed {
        logic        [FIELD_W-1:0] health;
        logic        [FIELD_W-1:0] humidity;
        logic signed [FIELD_W-1:0] temperature;
        logic        [FIELD_W-1:0] accepted;
        logic        [FIELD_W-1:0] raw;
    } record_t;

    typedef struct packed {
        logic               shift;
        logic               rotate;
        logic               health_wr;
        logic [FIELD_W-1:0] health;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/history_ring_buffer_core.sv */
// Top level of the history ring buffer: a chain of hrb_cell slots, newest in
// cell 0, with request decode, sequence counter and result register. Uses hrb_pkg.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid, in_stall | req_type, read_index, record fields, health_bits
//  out     | out_valid,out_stall| found, out_* record fields, sequence_value,
//          |                    | entry_count
//
// Append, update, sequence and read-miss transactions need no rotation; their result is registered on acceptance.
// A read hit rotates the whole chain once around, capturing the
// target record as it passes cell 0; the result is flagged valid when the rotation ends.
// Hold the input off while the chain rotates and while a result is stalled.
// Reset clears count, sequence counter and control; cell contents stay
// undefined until appended.
`default_nettype none

module history_ring_buffer_core
    import hrb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                req_type,
    input  wire logic [COUNT_W-1:0]        read_index,
    input  wire logic [FIELD_W-1:0]        raw_distance_mm,
    input  wire logic [FIELD_W-1:0]        accepted_distance_mm,
    input  wire logic signed [FIELD_W-1:0] temperature_centi_c,
    input  wire logic [FIELD_W-1:0]        humidity_centi_percent,
    input  wire logic [FIELD_W-1:0]        health_bits,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           found,
    output logic [FIELD_W-1:0]             out_raw_distance_mm,
    output logic [FIELD_W-1:0]             out_accepted_distance_mm,
    output logic signed [FIELD_W-1:0]      out_temperature_centi_c,
    output logic [FIELD_W-1:0]             out_humidity_centi_percent,
    output logic [FIELD_W-1:0]             out_health_bits,
    output logic [SEQ_W-1:0]               sequence_value,
    output logic [COUNT_W-1:0]             entry_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0]   LAST_STEP = IDX_W'(CAPACITY - 1);

    typedef enum logic {
        ST_IDLE,
        ST_ROTATE
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   step_reg;
    logic [IDX_W-1:0]   target_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic               out_valid_reg;
    logic               found_reg;
    record_t            result_reg;
    logic [SEQ_W-1:0]   seq_out_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic               accept;
    logic               take;
    req_t               req;
    logic               read_hit;
    logic [COUNT_W-1:0] target_full;
    logic [COUNT_W-1:0] count_inc;
    record_t            new_rec;
    cell_ctrl_t         ctrl;
    record_t            cells [CAPACITY];

    assign req      = req_t'(req_type);
    assign in_stall = (state_reg == ST_ROTATE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign take     = out_valid_reg && !out_stall;
    assign read_hit = read_index < count_reg;
    assign target_full = count_reg - COUNT_W'(1) - read_index;
    assign count_inc = (count_reg < CAP_COUNT) ? count_reg + COUNT_W'(1) : count_reg;

    always_comb
    begin
        new_rec.raw         = raw_distance_mm;
        new_rec.accepted    = accepted_distance_mm;
        new_rec.temperature = temperature_centi_c;
        new_rec.humidity    = humidity_centi_percent;
        new_rec.health      = health_bits;
    end

    always_comb
    begin
        ctrl.shift     = accept && (req == REQ_APPEND);
        ctrl.rotate    = (state_reg == ST_ROTATE);
        ctrl.health_wr = accept && (req == REQ_UPDATE) && (count_reg != '0);
        ctrl.health    = health_bits;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        hrb_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .newest    (i == 0),
            .from_prev ((i == 0) ? new_rec : cells[(i + CAPACITY - 1) % CAPACITY]),
            .from_next (cells[(i + 1) % CAPACITY]),
            .data      (cells[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            target_reg    <= '0;
            count_reg     <= '0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            result_reg    <= '0;
            seq_out_reg   <= '0;
            count_out_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        result_reg  <= '0;
                        seq_out_reg <= '0;
                        found_reg   <= 1'b0;
                        unique case (req)
                            REQ_APPEND:
                            begin
                                count_reg     <= count_inc;
                                count_out_reg <= count_inc;
                                out_valid_reg <= 1'b1;
                            end
                            REQ_READ:
                            begin
                                count_out_reg <= count_reg;
                                if (read_hit)
                                begin
                                    target_reg <= target_full[IDX_W-1:0];
                                    step_reg   <= '0;
                                    state_reg  <= ST_ROTATE;
                                end
                                else
                                begin
                                    out_valid_reg <= 1'b1;
                                end
                            end
                            REQ_UPDATE:
                            begin
                                found_reg     <= (count_reg != '0);
                                count_out_reg <= count_reg;
                                out_valid_reg <= 1'b1;
                            end
                            REQ_SEQ:
                            begin
                                seq_reg       <= seq_reg + SEQ_W'(1);
                                seq_out_reg   <= seq_reg + SEQ_W'(1);
                                count_out_reg <= count_reg;
                                out_valid_reg <= 1'b1;
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_ROTATE:
                begin
                    if (step_reg == target_reg)
                    begin
                        result_reg <= cells[0];
                    end
                    if (step_reg == LAST_STEP)
                    begin
                        found_reg     <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + IDX_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid                  = out_valid_reg;
    assign found                      = found_reg;
    assign out_raw_distance_mm        = result_reg.raw;
    assign out_accepted_distance_mm   = result_reg.accepted;
    assign out_temperature_centi_c    = result_reg.temperature;
    assign out_humidity_centi_percent = result_reg.humidity;
    assign out_health_bits            = result_reg.health;
    assign sequence_value             = seq_out_reg;
    assign entry_count                = count_out_reg;

endmodule

`default_nettype wire

/* hdl/hrb_cell.sv */
// One record slot of the history chain: shifts in from the newer neighbor,
// rotates in from the older neighbor, or rewrites its health word. Uses hrb_pkg.
`default_nettype none

module hrb_cell
    import hrb_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       newest,
    input  wire record_t    from_prev,
    input  wire record_t    from_next,
    output record_t         data
);

    record_t data_reg;
    record_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = from_prev;
        end
        else if (ctrl.rotate)
        begin
            data_next = from_next;
        end
        else if (ctrl.health_wr && newest)
        begin
            data_next.health = ctrl.health;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire
